// ----- design/prr_pkg.sv -----
package prr_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int DW = 32;          // field width
    localparam int QW = 32;          // quaternion component width
    localparam int MW = 33;          // rotation matrix entry, holds +-2^31
    localparam int RW = 40;          // transformed coordinate
    localparam int QUOT_W = 32;      // divider quotient bits
    localparam int KEY_WEIGHT = 1000;
    localparam int CFG_IW = 3;

    localparam logic [QW-1:0] QUAT_ONE = 32'h4000_0000;

    typedef enum logic [CFG_IW-1:0] {
        CFG_QUAT_W  = 3'd0,
        CFG_QUAT_X  = 3'd1,
        CFG_QUAT_Y  = 3'd2,
        CFG_QUAT_Z  = 3'd3,
        CFG_TRANS_X = 3'd4,
        CFG_TRANS_Y = 3'd5,
        CFG_TRANS_Z = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEPTH = 2'd1,
        ST_ZERO  = 2'd2
    } t_status;

    // rotation terms m[3*row+col], flag for a quaternion of zero length
    typedef struct packed {
        logic [8:0][MW-1:0] m;
        logic               zero;
    } t_rot;

    typedef struct packed {
        logic [DW-1:0] obs_u;
        logic [DW-1:0] obs_v;
        logic [DW-1:0] focal_x;
        logic [DW-1:0] center_x;
        logic [DW-1:0] focal_y;
        logic [DW-1:0] center_y;
    } t_xside;

    typedef struct packed {
        logic [2:0][DW-1:0] res;
        logic               depth;
        t_xside             frame;
    } t_dside;

    function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] x);
        logic signed [DW-1:0] y;
        if (x > 64'sh0000_0000_7fff_ffff) begin
            y = 32'sh7fff_ffff;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[DW-1:0];
        end
        return y;
    endfunction

endpackage

// ----- design/prr_norm.sv -----
module prr_norm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [3:0][prr_pkg::QW-1:0]       i_quat,
    output logic                              o_busy,
    output prr_pkg::t_rot                     o_rot
);

    localparam int QW = prr_pkg::QW;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQ   = 6'b000010,
        S_SQRT = 6'b000100,
        S_DIV  = 6'b001000,
        S_PROD = 6'b010000,
        S_MAT  = 6'b100000
    } t_state;

    // operand pairs of the nine quaternion products
    localparam logic [1:0] PA [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
    localparam logic [1:0] PB [9] = '{2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

    t_state                 r_state, n_state;
    logic [4:0]             r_cnt, n_cnt;
    logic [1:0]             r_idx, n_idx;
    logic [63:0]            r_acc, n_acc;
    logic [63:0]            r_root, n_root;
    logic [63:0]            r_rem, n_rem;
    logic [QW-1:0]          r_quo, n_quo;
    logic [3:0][QW-1:0]     r_u;
    logic [8:0][QW-1:0]     r_p;
    prr_pkg::t_rot          r_rot;

    logic signed [QW-1:0]   mul_a, mul_b;
    logic signed [63:0]     mul_p;
    logic [63:0]            bit_sq, sum_rb;
    logic signed [QW-1:0]   q_cur;
    logic [QW:0]            q_ext, q_mag;
    logic [63:0]            rem_cur, dsh;
    logic [QW-1:0]          quo_cur, u_mag, u_val;
    logic                   ge;
    logic [4:0]             sh;
    logic signed [prr_pkg::MW-1:0] pe [9];

    // shared multiplier: squares first, quaternion products later
    always_comb begin
        if (r_state == S_SQ) begin
            mul_a = $signed(i_quat[r_idx]);
            mul_b = $signed(i_quat[r_idx]);
        end else begin
            mul_a = $signed(r_u[PA[r_cnt[3:0]]]);
            mul_b = $signed(r_u[PB[r_cnt[3:0]]]);
        end
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        bit_sq  = 64'h4000_0000_0000_0000 >> {r_cnt, 1'b0};
        sum_rb  = r_root + bit_sq;
        q_cur   = $signed(i_quat[r_idx]);
        q_ext   = {q_cur[QW-1], q_cur};
        q_mag   = q_cur[QW-1] ? (QW+1)'(-q_ext) : q_ext;
        rem_cur = (r_cnt == 5'd0) ? (64'(q_mag) << 29) : r_rem;
        quo_cur = (r_cnt == 5'd0) ? '0 : r_quo;
        sh      = 5'd31 - r_cnt;
        dsh     = 64'(r_root[QW-1:0]) << sh;
        ge      = rem_cur >= dsh;
        for (int k = 0; k < 9; k++) begin
            pe[k] = prr_pkg::MW'($signed(r_p[k]));
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_acc   = r_acc;
        n_root  = r_root;
        n_rem   = r_rem;
        n_quo   = r_quo;
        u_mag   = '0;
        u_val   = '0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_SQ: begin
                n_acc = r_acc + {2'b00, mul_p[63:2]};
                n_idx = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    n_state = S_SQRT;
                    n_cnt   = '0;
                    n_root  = '0;
                end
            end
            S_SQRT: begin
                if (r_acc >= sum_rb) begin
                    n_acc  = r_acc - sum_rb;
                    n_root = (r_root >> 1) + bit_sq;
                end else begin
                    n_root = r_root >> 1;
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_cnt = '0;
                    n_idx = '0;
                    n_state = (n_root == '0) ? S_IDLE : S_DIV;
                end
            end
            S_DIV: begin
                n_rem = ge ? rem_cur - dsh : rem_cur;
                n_quo = {quo_cur[QW-2:0], ge};
                u_mag = (n_quo[QW-1] || n_quo > prr_pkg::QUAT_ONE) ? prr_pkg::QUAT_ONE : n_quo;
                u_val = q_cur[QW-1] ? QW'(-u_mag) : u_mag;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_cnt = '0;
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        n_state = S_PROD;
                    end
                end
            end
            S_PROD: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd8) begin
                    n_state = S_MAT;
                end
            end
            S_MAT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_start) begin
            n_state = S_SQ;
            n_cnt   = '0;
            n_idx   = '0;
            n_acc   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SQ;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root <= n_root;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        if (r_state == S_DIV && r_cnt == 5'd31) begin
            r_u[r_idx] <= u_val;
        end
        if (r_state == S_PROD) begin
            r_p[r_cnt[3:0]] <= mul_p[61:30];
        end
        if (r_state == S_SQRT && r_cnt == 5'd31) begin
            r_rot.zero <= (n_root == '0);
        end
        if (r_state == S_MAT) begin
            r_rot.m[0] <= -pe[6] - pe[8];
            r_rot.m[1] <=  pe[4] - pe[2];
            r_rot.m[2] <=  pe[1] + pe[5];
            r_rot.m[3] <=  pe[2] + pe[4];
            r_rot.m[4] <= -pe[3] - pe[8];
            r_rot.m[5] <=  pe[7] - pe[0];
            r_rot.m[6] <=  pe[5] - pe[1];
            r_rot.m[7] <=  pe[0] + pe[7];
            r_rot.m[8] <= -pe[3] - pe[6];
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_rot  = r_rot;

endmodule

// ----- design/prr_xform.sv -----
module prr_xform #(
    parameter int COORD_FRAC_BITS = prr_pkg::COORD_FRAC_BITS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic [2:0][prr_pkg::DW-1:0]                   i_model,
    input  logic [2:0][prr_pkg::DW-1:0]                   i_key,
    input  logic [2:0][prr_pkg::DW-1:0]                   i_trans,
    input  prr_pkg::t_rot                                 i_rot,
    input  prr_pkg::t_xside                               i_side,
    output logic                                          o_valid,
    output logic [2:0][prr_pkg::DW-1:0]                   o_res,
    output logic [1:0][prr_pkg::RW+COORD_FRAC_BITS-1:0]   o_num,
    output logic [1:0]                                    o_neg,
    output logic [prr_pkg::RW-1:0]                        o_den,
    output logic                                          o_depth,
    output prr_pkg::t_xside                               o_side
);

    localparam int DW    = prr_pkg::DW;
    localparam int RW    = prr_pkg::RW;
    localparam int MW    = prr_pkg::MW;
    localparam int PW    = MW + DW;
    localparam int TW    = PW - 30;
    localparam int NUM_W = RW + COORD_FRAC_BITS;
    localparam int WW    = RW + 11;

    logic                  r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [DW-1:0]  r1_m [3];
    logic signed [DW-1:0]  r1_key [3];
    prr_pkg::t_xside       r1_side;
    logic signed [TW-1:0]  r2_t [3][3];
    logic signed [DW-1:0]  r2_m [3];
    logic signed [DW-1:0]  r2_key [3];
    prr_pkg::t_xside       r2_side;
    logic signed [RW-1:0]  r3_r [3];
    logic signed [DW-1:0]  r3_key [3];
    prr_pkg::t_xside       r3_side;
    logic signed [RW:0]    r4_diff [3];
    logic [NUM_W-1:0]      r4_num [2];
    logic [1:0]            r4_neg;
    logic [RW-1:0]         r4_den;
    logic                  r4_depth;
    prr_pkg::t_xside       r4_side;
    logic [2:0][DW-1:0]    r5_res;
    logic [NUM_W-1:0]      r5_num [2];
    logic [1:0]            r5_neg;
    logic [RW-1:0]         r5_den;
    logic                  r5_depth;
    prr_pkg::t_xside       r5_side;

    logic signed [PW-1:0]  prod [3][3];
    logic [RW-1:0]         mag [2];
    logic signed [WW-1:0]  wdiff [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod[i][j] = $signed(i_rot.m[3*i+j]) * r1_m[j];
            end
            wdiff[i] = WW'(r4_diff[i]) * WW'(prr_pkg::KEY_WEIGHT);
        end
        for (int i = 0; i < 2; i++) begin
            mag[i] = r3_r[i][RW-1] ? RW'(-r3_r[i]) : RW'(r3_r[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_m[i]   <= $signed(i_model[i]);
                r1_key[i] <= $signed(i_key[i]);
                for (int j = 0; j < 3; j++) begin
                    r2_t[i][j] <= prod[i][j][PW-1:30];
                end
                r2_m[i]   <= r1_m[i];
                r2_key[i] <= r1_key[i];
                r3_r[i]   <= ((RW'(r2_t[i][0]) + RW'(r2_t[i][1]) + RW'(r2_t[i][2])) <<< 1)
                             + RW'(r2_m[i]) + RW'($signed(i_trans[i]));
                r3_key[i] <= r2_key[i];
                r4_diff[i] <= (RW+1)'(r3_r[i]) - (RW+1)'(r3_key[i]);
                r5_res[i]  <= prr_pkg::sat32(64'(wdiff[i]));
            end
            for (int i = 0; i < 2; i++) begin
                r4_num[i] <= {mag[i], {COORD_FRAC_BITS{1'b0}}};
                r5_num[i] <= r4_num[i];
            end
            r1_side  <= i_side;
            r2_side  <= r1_side;
            r3_side  <= r2_side;
            r4_side  <= r3_side;
            r5_side  <= r4_side;
            r4_neg   <= {r3_r[1][RW-1], r3_r[0][RW-1]};
            r4_den   <= r3_r[2];
            // depth must be strictly positive to project
            r4_depth <= r3_r[2][RW-1] || (r3_r[2] == '0);
            r5_neg   <= r4_neg;
            r5_den   <= r4_den;
            r5_depth <= r4_depth;
        end
    end

    assign o_valid  = r_v5;
    assign o_res    = r5_res;
    assign o_num[0] = r5_num[0];
    assign o_num[1] = r5_num[1];
    assign o_neg    = r5_neg;
    assign o_den    = r5_den;
    assign o_depth  = r5_depth;
    assign o_side   = r5_side;

endmodule

// ----- design/prr_div.sv -----
module prr_div #(
    parameter int COORD_FRAC_BITS = prr_pkg::COORD_FRAC_BITS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic [1:0][prr_pkg::RW+COORD_FRAC_BITS-1:0]   i_num,
    input  logic [1:0]                                    i_neg,
    input  logic [prr_pkg::RW-1:0]                        i_den,
    input  prr_pkg::t_dside                               i_side,
    output logic                                          o_valid,
    output logic [1:0][prr_pkg::DW-1:0]                   o_ratio,
    output prr_pkg::t_dside                               o_side
);

    localparam int RW    = prr_pkg::RW;
    localparam int QW    = prr_pkg::QUOT_W;
    localparam int NUM_W = RW + COORD_FRAC_BITS;
    localparam int CW    = NUM_W + QW;
    localparam int NSTG  = QW;

    logic [NUM_W-1:0]  r_rem  [NSTG-1][2];
    logic [RW-1:0]     r_den  [NSTG-1];
    logic [QW-1:0]     r_quo  [NSTG][2];
    logic [1:0]        r_neg  [NSTG];
    prr_pkg::t_dside   r_side [NSTG];
    logic              r_v    [NSTG];

    logic [1:0][QW-1:0] r_ratio;
    prr_pkg::t_dside    r_fside;
    logic               r_fv;

    // one quotient bit per stage, the first one flags a quotient of 2^31 or more
    for (genvar k = 0; k < NSTG; k++) begin : g_st
        localparam int SH = QW - 1 - k;
        logic [NUM_W-1:0] src_rem [2];
        logic [QW-1:0]    src_quo [2];
        logic [RW-1:0]    src_den;
        logic [1:0]       src_neg;
        prr_pkg::t_dside  src_side;
        logic             src_v;
        logic [CW:0]      trial [2];
        logic             ge [2];

        if (k == 0) begin : g_head
            always_comb begin
                src_rem[0] = i_num[0];
                src_rem[1] = i_num[1];
                src_quo[0] = '0;
                src_quo[1] = '0;
                src_den    = i_den;
                src_neg    = i_neg;
                src_side   = i_side;
                src_v      = i_valid;
            end
        end else begin : g_link
            always_comb begin
                src_rem[0] = r_rem[k-1][0];
                src_rem[1] = r_rem[k-1][1];
                src_quo[0] = r_quo[k-1][0];
                src_quo[1] = r_quo[k-1][1];
                src_den    = r_den[k-1];
                src_neg    = r_neg[k-1];
                src_side   = r_side[k-1];
                src_v      = r_v[k-1];
            end
        end

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                trial[l] = {1'b0, CW'(src_rem[l])} - ({1'b0, CW'(src_den)} << SH);
                ge[l]    = !trial[l][CW];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 2; l++) begin
                    r_quo[k][l] <= {src_quo[l][QW-2:0], ge[l]};
                end
                r_neg[k]  <= src_neg;
                r_side[k] <= src_side;
            end
        end

        if (k < NSTG - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int l = 0; l < 2; l++) begin
                        r_rem[k][l] <= ge[l] ? trial[l][NUM_W-1:0] : src_rem[l];
                    end
                    r_den[k] <= src_den;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_en) begin
            r_fv <= r_v[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                if (r_quo[NSTG-1][l][QW-1]) begin
                    r_ratio[l] <= r_neg[NSTG-1][l] ? 32'h8000_0000 : 32'h7fff_ffff;
                end else if (r_neg[NSTG-1][l]) begin
                    r_ratio[l] <= QW'(-{1'b0, r_quo[NSTG-1][l][QW-2:0]});
                end else begin
                    r_ratio[l] <= {1'b0, r_quo[NSTG-1][l][QW-2:0]};
                end
            end
            r_fside <= r_side[NSTG-1];
        end
    end

    assign o_valid = r_fv;
    assign o_ratio = r_ratio;
    assign o_side  = r_fside;

endmodule

// ----- design/prr_proj.sv -----
module prr_proj #(
    parameter int COORD_FRAC_BITS = prr_pkg::COORD_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [1:0][prr_pkg::DW-1:0]  i_ratio,
    input  prr_pkg::t_dside              i_side,
    input  logic                         i_zero,
    output logic                         o_valid,
    output logic [prr_pkg::DW-1:0]       o_res_u,
    output logic [prr_pkg::DW-1:0]       o_res_v,
    output logic [prr_pkg::DW-1:0]       o_res_x,
    output logic [prr_pkg::DW-1:0]       o_res_y,
    output logic [prr_pkg::DW-1:0]       o_res_z,
    output prr_pkg::t_status             o_status
);

    localparam int DW = prr_pkg::DW;

    logic                  r_v1, r_v2;
    logic signed [63:0]    r1_prod [2];
    logic signed [DW-1:0]  r1_center [2];
    logic signed [DW-1:0]  r1_obs [2];
    logic [2:0][DW-1:0]    r1_res;
    logic                  r1_depth;
    logic [DW-1:0]         r_res_u, r_res_v, r_res_x, r_res_y, r_res_z;
    prr_pkg::t_status      r_status;

    logic signed [DW-1:0]  focal [2];
    logic signed [63:0]    pix [2];
    logic signed [DW-1:0]  pix_sat [2];

    always_comb begin
        focal[0] = $signed(i_side.frame.focal_x);
        focal[1] = $signed(i_side.frame.focal_y);
        for (int a = 0; a < 2; a++) begin
            pix[a]     = (r1_prod[a] >>> COORD_FRAC_BITS) + 64'(r1_center[a]) - 64'(r1_obs[a]);
            pix_sat[a] = prr_pkg::sat32(pix[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 2; a++) begin
                r1_prod[a] <= $signed(i_ratio[a]) * focal[a];
            end
            r1_center[0] <= $signed(i_side.frame.center_x);
            r1_center[1] <= $signed(i_side.frame.center_y);
            r1_obs[0]    <= $signed(i_side.frame.obs_u);
            r1_obs[1]    <= $signed(i_side.frame.obs_v);
            r1_res       <= i_side.res;
            r1_depth     <= i_side.depth;
            priority if (i_zero) begin
                r_status <= prr_pkg::ST_ZERO;
                r_res_u  <= '0;
                r_res_v  <= '0;
                r_res_x  <= '0;
                r_res_y  <= '0;
                r_res_z  <= '0;
            end else if (r1_depth) begin
                r_status <= prr_pkg::ST_DEPTH;
                r_res_u  <= '0;
                r_res_v  <= '0;
                r_res_x  <= r1_res[0];
                r_res_y  <= r1_res[1];
                r_res_z  <= r1_res[2];
            end else begin
                r_status <= prr_pkg::ST_OK;
                r_res_u  <= pix_sat[0];
                r_res_v  <= pix_sat[1];
                r_res_x  <= r1_res[0];
                r_res_y  <= r1_res[1];
                r_res_z  <= r1_res[2];
            end
        end
    end

    assign o_valid  = r_v2;
    assign o_res_u  = r_res_u;
    assign o_res_v  = r_res_v;
    assign o_res_x  = r_res_x;
    assign o_res_y  = r_res_y;
    assign o_res_z  = r_res_z;
    assign o_status = r_status;

endmodule

// ----- design/pose_reprojection_residual.sv -----
// channel   direction  handshake                    payload
// in        sink       i_in_valid / o_in_ready      model, obs, key, intrinsics
// out       source     o_out_valid / i_out_ready    res_u..res_z, status
// cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// one transaction per cycle while o_in_ready is high; data passes transform, divider and projection in order
// the 32-stage restoring divider for the projection ratio sets the depth
// after reset and after every register write the quaternion is normalised and the
// rotation terms rebuilt serially (a zero quaternion stops after the square root) while o_in_ready is low
// the whole pipeline advances together; it holds only while a result waits at the output
module pose_reprojection_residual #(
    parameter int COORD_FRAC_BITS = prr_pkg::COORD_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [prr_pkg::DW-1:0]        i_model_x,
    input  logic [prr_pkg::DW-1:0]        i_model_y,
    input  logic [prr_pkg::DW-1:0]        i_model_z,
    input  logic [prr_pkg::DW-1:0]        i_obs_u,
    input  logic [prr_pkg::DW-1:0]        i_obs_v,
    input  logic [prr_pkg::DW-1:0]        i_key_x,
    input  logic [prr_pkg::DW-1:0]        i_key_y,
    input  logic [prr_pkg::DW-1:0]        i_key_z,
    input  logic [prr_pkg::DW-1:0]        i_focal_x,
    input  logic [prr_pkg::DW-1:0]        i_center_x,
    input  logic [prr_pkg::DW-1:0]        i_focal_y,
    input  logic [prr_pkg::DW-1:0]        i_center_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [prr_pkg::DW-1:0]        o_res_u,
    output logic [prr_pkg::DW-1:0]        o_res_v,
    output logic [prr_pkg::DW-1:0]        o_res_x,
    output logic [prr_pkg::DW-1:0]        o_res_y,
    output logic [prr_pkg::DW-1:0]        o_res_z,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [prr_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [prr_pkg::DW-1:0]        i_cfg_data
);

    localparam int DW    = prr_pkg::DW;
    localparam int RW    = prr_pkg::RW;
    localparam int NUM_W = RW + COORD_FRAC_BITS;

    logic [3:0][prr_pkg::QW-1:0]  r_quat;
    logic [2:0][DW-1:0]           r_trans;

    logic                  en, busy, cfg_wr;
    prr_pkg::t_rot         rot;
    prr_pkg::t_xside       in_side, x_side;
    prr_pkg::t_dside       d_side_in, d_side;
    prr_pkg::t_status      status;
    logic                  x_valid, d_valid;
    logic [2:0][DW-1:0]    x_res;
    logic [1:0][NUM_W-1:0] x_num;
    logic [1:0]            x_neg;
    logic [RW-1:0]         x_den;
    logic                  x_depth;
    logic [1:0][DW-1:0]    d_ratio;

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en && !busy;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat  <= {32'd0, 32'd0, 32'd0, prr_pkg::QUAT_ONE};
            r_trans <= '0;
        end else if (cfg_wr) begin
            unique case (prr_pkg::t_cfg_idx'(i_cfg_index))
                prr_pkg::CFG_QUAT_W:  r_quat[0]  <= i_cfg_data;
                prr_pkg::CFG_QUAT_X:  r_quat[1]  <= i_cfg_data;
                prr_pkg::CFG_QUAT_Y:  r_quat[2]  <= i_cfg_data;
                prr_pkg::CFG_QUAT_Z:  r_quat[3]  <= i_cfg_data;
                prr_pkg::CFG_TRANS_X: r_trans[0] <= i_cfg_data;
                prr_pkg::CFG_TRANS_Y: r_trans[1] <= i_cfg_data;
                prr_pkg::CFG_TRANS_Z: r_trans[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    prr_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cfg_wr),
        .i_quat  (r_quat),
        .o_busy  (busy),
        .o_rot   (rot)
    );

    assign in_side.obs_u    = i_obs_u;
    assign in_side.obs_v    = i_obs_v;
    assign in_side.focal_x  = i_focal_x;
    assign in_side.center_x = i_center_x;
    assign in_side.focal_y  = i_focal_y;
    assign in_side.center_y = i_center_y;

    prr_xform #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid && o_in_ready),
        .i_model ({i_model_z, i_model_y, i_model_x}),
        .i_key   ({i_key_z, i_key_y, i_key_x}),
        .i_trans (r_trans),
        .i_rot   (rot),
        .i_side  (in_side),
        .o_valid (x_valid),
        .o_res   (x_res),
        .o_num   (x_num),
        .o_neg   (x_neg),
        .o_den   (x_den),
        .o_depth (x_depth),
        .o_side  (x_side)
    );

    assign d_side_in.res   = x_res;
    assign d_side_in.depth = x_depth;
    assign d_side_in.frame = x_side;

    prr_div #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (x_valid),
        .i_num   (x_num),
        .i_neg   (x_neg),
        .i_den   (x_den),
        .i_side  (d_side_in),
        .o_valid (d_valid),
        .o_ratio (d_ratio),
        .o_side  (d_side)
    );

    prr_proj #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_proj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (d_valid),
        .i_ratio  (d_ratio),
        .i_side   (d_side),
        .i_zero   (rot.zero),
        .o_valid  (o_out_valid),
        .o_res_u  (o_res_u),
        .o_res_v  (o_res_v),
        .o_res_x  (o_res_x),
        .o_res_y  (o_res_y),
        .o_res_z  (o_res_z),
        .o_status (status)
    );

    assign o_status = status;

    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == prr_pkg::ST_ZERO |->
            o_res_u == '0 && o_res_v == '0 && o_res_x == '0 && o_res_y == '0 && o_res_z == '0)
        else $error("zero quaternion result carries nonzero residuals");

    a_depth_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == prr_pkg::ST_DEPTH |-> o_res_u == '0 && o_res_v == '0)
        else $error("depth fault result carries pixel residuals");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != 2'd3)
        else $error("undefined status code");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_in_ready)
        else $error("input taken while rotation terms are rebuilt");

endmodule
